// File: src/vmt_pkg.sv
// ----------------------------------------------------------------------------
// vmt_pkg
// Shared widths, reset matrix and the output scaling function of the
// 4x4 matrix by 4-vector transform.
// ----------------------------------------------------------------------------
`default_nettype none

package vmt_pkg;

  localparam int unsigned CompW    = 32;          // Q16.16 component
  localparam int unsigned NumComp  = 4;           // vector length
  localparam int unsigned NumRegs  = 8;           // coefficient pair registers
  localparam int unsigned RegW     = 2 * CompW;   // one register holds two coefficients
  localparam int unsigned AddrW    = $clog2(NumRegs);
  localparam int unsigned ProdW    = 2 * CompW;   // exact product
  localparam int unsigned PairW    = ProdW + 1;   // sum of two products
  localparam int unsigned SumW     = ProdW + 2;   // sum of four products
  localparam int unsigned FracW    = 16;          // fraction bits dropped by the shift
  localparam int unsigned ShW      = SumW - FracW;
  localparam int unsigned DataW    = NumComp * CompW;

  typedef logic [NumComp-1:0][CompW-1:0] vec_t;
  typedef logic [NumRegs-1:0][RegW-1:0]  mat_t;

  // Identity matrix: diagonal coefficients 0, 5, 10 and 15 are 1.0
  localparam mat_t MatReset = '{
    7: 64'h0001_0000_0000_0000,
    6: 64'h0,
    5: 64'h0000_0000_0001_0000,
    4: 64'h0,
    3: 64'h0,
    2: 64'h0001_0000_0000_0000,
    1: 64'h0,
    0: 64'h0000_0000_0001_0000
  };

  localparam logic [CompW-1:0] SatMax = {1'b0, {(CompW-1){1'b1}}};
  localparam logic [CompW-1:0] SatMin = {1'b1, {(CompW-1){1'b0}}};

  // Floor-shift the exact sum by the fraction width and clamp to a component
  function automatic logic [CompW-1:0] sat_q16(input logic [SumW-1:0] s);
    logic [ShW-1:0] sh;
    sh = s[SumW-1:FracW];
    if (sh[ShW-1:CompW-1] == {(ShW-CompW+1){sh[ShW-1]}}) begin
      return sh[CompW-1:0];
    end else if (sh[ShW-1]) begin
      return SatMin;
    end else begin
      return SatMax;
    end
  endfunction

endpackage

`default_nettype wire

// File: src/vec4_matrix_transform.sv
// ----------------------------------------------------------------------------
// vec4_matrix_transform
// Multiplies each Q16.16 4-vector by a column-major 4x4 matrix held in
// configuration registers, with floor scaling and saturation.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+-------------------------------
//   s_*     | in  | s_tvalid / s_tready  | s_tdata: vx, vy, vz, vw
//   m_*     | out | m_tvalid / m_tready  | m_tdata: rx, ry, rz, rw
//   cfg_*   | in  | cfg_we               | cfg_addr, cfg_wdata (coef pair)
//
// One beat per cycle sustained while the output is not stalled; four lanes
// run in parallel, one per output component. An input beat passes through
// the product, pair-sum, total and output registers in that order.
// A stalled output freezes the lane pipeline; the input skid holds one more
// beat, and s_tready comes from a register. Synchronous reset clears the
// valid bits and loads the identity matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module vec4_matrix_transform
  import vmt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  // input stream
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [DataW-1:0] s_tdata,   // vx, vy, vz, vw from bit 0 up
  // output stream
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [DataW-1:0]      m_tdata,   // rx, ry, rz, rw from bit 0 up
  // configuration
  input  wire logic             cfg_we,
  input  wire logic [AddrW-1:0] cfg_addr,
  input  wire logic [RegW-1:0]  cfg_wdata
);

  mat_t             mat;
  logic             en;
  logic             beat_valid;
  logic [DataW-1:0] beat_data;
  logic             v1;
  logic             v2;
  logic             v3;
  vec_t             lane_res;

  // Pipeline moves whenever the output register is free or being drained
  assign en = !m_tvalid || m_tready;

  // Coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mat <= MatReset;
    end else if (cfg_we) begin
      mat[cfg_addr] <= cfg_wdata;
    end
  end

  vmt_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .en        (en),
    .beat_valid(beat_valid),
    .beat_data (beat_data)
  );

  // One lane per output component; lane i uses coefficients 4j+i
  for (genvar i = 0; i < NumComp; i++) begin : g_lane
    vec_t coef;
    for (genvar j = 0; j < NumComp; j++) begin : g_coef
      assign coef[j] = mat[(NumComp*j + i) / 2][((i % 2) * CompW) +: CompW];
    end
    vmt_lane u_lane (
      .clk (clk),
      .en  (en),
      .vec (vec_t'(beat_data)),
      .coef(coef),
      .res (lane_res[i])
    );
  end

  // Valid bits alongside the lane stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v1       <= beat_valid;
      v2       <= v1;
      v3       <= v2;
      m_tvalid <= v3;
    end
  end

  // Merge lane results into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= DataW'(lane_res);
    end
  end

  // The skid fills only while the pipeline is stalled
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $fell(s_tready) |-> $past(!en))
    else $error("skid filled while pipeline was moving");

  // A beat in flight advances one stage when the pipeline moves
  a_advance: assert property (@(posedge clk) disable iff (rst)
    en && v2 |=> v3)
    else $error("pipeline stage lost a beat");

  // A stall freezes every stage
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v1) && $stable(v2) && $stable(v3))
    else $error("pipeline moved during a stall");

  // Reset leaves the identity matrix
  a_reset_ident: assert property (@(posedge clk)
    $past(rst) && !$past(cfg_we) |-> mat == MatReset)
    else $error("coefficients not identity after reset");

endmodule

`default_nettype wire

// File: src/vmt_skid.sv
// ----------------------------------------------------------------------------
// vmt_skid
// Input skid stage: registered tready, holds one beat while the pipeline
// is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module vmt_skid
  import vmt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [DataW-1:0] s_tdata,
  input  wire logic             en,        // pipeline takes a beat this cycle
  output logic                  beat_valid,
  output logic [DataW-1:0]      beat_data
);

  logic             skid_valid;
  logic [DataW-1:0] skid_data;

  assign s_tready   = !skid_valid;
  assign beat_valid = skid_valid || s_tvalid;
  assign beat_data  = skid_valid ? skid_data : s_tdata;

  // Hold a beat when it arrives during a stall, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en) begin
      skid_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && s_tvalid && s_tready) begin
      skid_data <= s_tdata;
    end
  end

endmodule

`default_nettype wire

// File: src/vmt_lane.sv
// ----------------------------------------------------------------------------
// vmt_lane
// One output component: four products, a two-level adder tree, and the
// floor shift with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module vmt_lane
  import vmt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             en,
  input  wire vec_t             vec,   // input vector components
  input  wire vec_t             coef,  // matrix row for this component
  output logic [CompW-1:0]      res
);

  logic signed [NumComp-1:0][ProdW-1:0] prod;
  logic signed [PairW-1:0]              pair0;
  logic signed [PairW-1:0]              pair1;
  logic signed [SumW-1:0]               sum;

  // Stage 1: exact signed products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NumComp; j++) begin
        prod[j] <= ProdW'($signed(vec[j]) * $signed(coef[j]));
      end
    end
  end

  // Stage 2: pairwise sums, stage 3: total
  always_ff @(posedge clk) begin
    if (en) begin
      pair0 <= PairW'($signed(prod[0])) + PairW'($signed(prod[1]));
      pair1 <= PairW'($signed(prod[2])) + PairW'($signed(prod[3]));
      sum   <= SumW'(pair0) + SumW'(pair1);
    end
  end

  assign res = sat_q16(sum);

endmodule

`default_nettype wire
